// File: hdl/pidd_pkg.sv
// Shared widths, codes and types for the deadband PID controller.
package pidd_pkg;

  localparam int unsigned SampleW   = 24;
  localparam int unsigned SumW      = 40;
  localparam int unsigned ErrW      = SampleW + 1;
  localparam int unsigned DeltaW    = ErrW + 1;
  localparam int unsigned GainW     = 24;
  localparam int unsigned DbWidthW  = 23;
  localparam int unsigned LimitW    = 39;
  localparam int unsigned DriveW    = 32;
  localparam int unsigned FracShift = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 39;

  localparam int unsigned MagCmpW = (ErrW > DbWidthW) ? ErrW : DbWidthW;
  localparam int unsigned LimCmpW = (LimitW > SumW) ? LimitW : SumW;
  localparam int unsigned AddW    = ((SumW > ErrW) ? SumW : ErrW) + 1;
  localparam int unsigned SumLoW  = SumW / 2;
  localparam int unsigned SumHiW  = SumW - SumLoW;
  localparam int unsigned MaxOpW  = (SumW > DeltaW) ? SumW : DeltaW;
  localparam int unsigned AccW    = GainW + MaxOpW + 3;
  localparam int unsigned ShW     = AccW - FracShift;

  localparam logic signed [ErrW-1:0]   ErrOne     = ErrW'(256);
  localparam logic [LimitW-1:0]        LimitReset = LimitW'(256000);
  localparam logic signed [SumW-1:0]   SumMax     = {1'b0, {(SumW-1){1'b1}}};
  localparam logic signed [SumW-1:0]   SumMin     = {1'b1, {(SumW-1){1'b0}}};
  localparam logic signed [DriveW-1:0] DriveMax   = {1'b0, {(DriveW-1){1'b1}}};
  localparam logic signed [DriveW-1:0] DriveMin   = {1'b1, {(DriveW-1){1'b0}}};

  typedef enum logic [1:0] {
    DbZeroClear = 2'd0,
    DbZero      = 2'd1,
    DbNone      = 2'd2,
    DbForceOne  = 2'd3
  } db_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegGainP    = 3'd0,
    RegGainI    = 3'd1,
    RegGainD    = 3'd2,
    RegDbMode   = 3'd3,
    RegDbWidth  = 3'd4,
    RegIntLimit = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    db_mode_e              mode;
    logic [DbWidthW-1:0]   width;
    logic [LimitW-1:0]     limit;
  } db_cfg_t;

  typedef struct packed {
    logic [GainW-1:0] p;
    logic [GainW-1:0] i;
    logic [GainW-1:0] d;
  } gains_t;

  typedef struct packed {
    logic [ErrW-1:0]   err;
    logic [DeltaW-1:0] delta;
    logic [SumW-1:0]   sum;
  } shaped_t;

endpackage

// File: hdl/pidd_shaper.sv
// Deadband shaping, saturating integral and derivative difference.
module pidd_shaper import pidd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic                       update_i,
  input  db_cfg_t                    cfg_i,
  input  logic signed [SampleW-1:0]  setpoint_i,
  input  logic signed [SampleW-1:0]  measured_i,
  output shaped_t                    shaped_o
);

  logic signed [SumW-1:0]    sum_q, sum_d;
  logic signed [ErrW-1:0]    prev_q;
  logic signed [ErrW-1:0]    err_raw, err_shp;
  logic [ErrW-1:0]           mag;
  logic [MagCmpW-1:0]        mag_c, dw_c;
  logic                      in_le, in_lt;
  logic signed [SumW-1:0]    base;
  logic signed [AddW-1:0]    add_w;
  logic signed [SumW-1:0]    sat;
  logic [LimCmpW-1:0]        lim_ext, smax_ext, lim_c;
  logic signed [SumW-1:0]    lim_s, lim_n;
  logic signed [DeltaW-1:0]  delta;
  shaped_t                   shaped_q;

  always_comb begin
    err_raw = ErrW'(setpoint_i) - ErrW'(measured_i);
    mag     = err_raw[ErrW-1] ? ErrW'(-err_raw) : err_raw;
    mag_c   = MagCmpW'(mag);
    dw_c    = MagCmpW'(cfg_i.width);
    in_le   = (mag_c <= dw_c);
    in_lt   = (mag_c < dw_c);

    err_shp = err_raw;
    base    = sum_q;
    case (cfg_i.mode)
      DbZeroClear: begin
        if (in_le) begin
          err_shp = '0;
          base    = '0;
        end
      end
      DbZero: begin
        if (in_lt) err_shp = '0;
      end
      DbForceOne: begin
        if (in_lt) err_shp = ErrOne;
      end
      default: ;
    endcase

    // saturate the integral at its own range
    add_w = AddW'(base) + AddW'(err_shp);
    if (add_w > AddW'(SumMax)) begin
      sat = SumMax;
    end else if (add_w < AddW'(SumMin)) begin
      sat = SumMin;
    end else begin
      sat = add_w[SumW-1:0];
    end

    lim_ext  = LimCmpW'(cfg_i.limit);
    smax_ext = LimCmpW'(SumMax);
    lim_c    = (lim_ext > smax_ext) ? smax_ext : lim_ext;
    lim_s    = $signed(lim_c[SumW-1:0]);
    lim_n    = -lim_s;

    sum_d = sat;
    if (cfg_i.mode == DbForceOne) begin
      if (sat >= lim_s) begin
        sum_d = lim_s;
      end else if (sat < lim_n) begin
        sum_d = lim_n;
      end
    end

    delta = DeltaW'(err_shp) - DeltaW'(prev_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
    end else if (update_i) begin
      sum_q  <= sum_d;
      prev_q <= err_shp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      shaped_q.err   <= err_shp;
      shaped_q.delta <= delta;
      shaped_q.sum   <= sum_d;
    end
  end

  assign shaped_o = shaped_q;

endmodule

// File: hdl/pidd_mac.sv
// Gain multiplies, term sum, fixed point rescale and output saturation.
module pidd_mac import pidd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      advance_i,
  input  gains_t                    gains_i,
  input  shaped_t                   shaped_i,
  output logic signed [DriveW-1:0]  drive_o
);

  localparam int unsigned PW   = GainW + 1 + ErrW;
  localparam int unsigned DW   = GainW + 1 + DeltaW;
  localparam int unsigned ILoW = GainW + 1 + SumLoW + 1;
  localparam int unsigned IHiW = GainW + 1 + SumHiW;

  logic signed [PW-1:0]     p_q;
  logic signed [DW-1:0]     d_q;
  logic signed [ILoW-1:0]   ilo_q;
  logic signed [IHiW-1:0]   ihi_q;
  logic signed [AccW-1:0]   acc;
  logic signed [ShW-1:0]    sh;
  logic signed [DriveW-1:0] drive_d, drive_q;

  // integral product split into low and high halves of the sum
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      p_q   <= $signed({1'b0, gains_i.p}) * $signed(shaped_i.err);
      d_q   <= $signed({1'b0, gains_i.d}) * $signed(shaped_i.delta);
      ilo_q <= $signed({1'b0, gains_i.i}) * $signed({1'b0, shaped_i.sum[SumLoW-1:0]});
      ihi_q <= $signed({1'b0, gains_i.i}) * $signed(shaped_i.sum[SumW-1:SumLoW]);
    end
  end

  always_comb begin
    acc = AccW'(p_q) + AccW'(d_q) + AccW'(ilo_q) + (AccW'(ihi_q) <<< SumLoW);
    sh  = acc[AccW-1:FracShift];
    if (sh > ShW'(DriveMax)) begin
      drive_d = DriveMax;
    end else if (sh < ShW'(DriveMin)) begin
      drive_d = DriveMin;
    end else begin
      drive_d = sh[DriveW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) drive_q <= drive_d;
  end

  assign drive_o = drive_q;

endmodule

// File: hdl/positional_pid_with_deadband.sv
// A word taken into sp_q/ms_q moves through shaped_q and the product registers to drive_q.
// Throughput: one word per cycle unless stalled; the integral loops through sum_q alone.
// The pipeline moves as a whole; it holds only while a result waits unread.
// Reset clears pipeline valids, integral and last error, and loads register
// defaults (gains zero, mode none, width zero, limit 256000); no clearing pass.
module positional_pid_with_deadband import pidd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] setpoint_i,
  input  logic signed [SampleW-1:0] measured_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [DriveW-1:0]  drive_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i
);

  gains_t                    gains_q;
  db_cfg_t                   db_cfg_q;
  logic signed [SampleW-1:0] sp_q, ms_q;
  logic                      s0_vld_q, s1_vld_q, s2_vld_q, out_vld_q;
  logic                      advance;
  shaped_t                   shaped;

  assign advance     = !out_vld_q || out_ready_i;
  assign in_ready_o  = advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q        <= '0;
      db_cfg_q.mode  <= DbNone;
      db_cfg_q.width <= '0;
      db_cfg_q.limit <= LimitReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegGainP:    gains_q.p      <= cfg_data_i[GainW-1:0];
        RegGainI:    gains_q.i      <= cfg_data_i[GainW-1:0];
        RegGainD:    gains_q.d      <= cfg_data_i[GainW-1:0];
        RegDbMode:   db_cfg_q.mode  <= db_mode_e'(cfg_data_i[1:0]);
        RegDbWidth:  db_cfg_q.width <= cfg_data_i[DbWidthW-1:0];
        RegIntLimit: db_cfg_q.limit <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      s0_vld_q  <= in_valid_i;
      s1_vld_q  <= s0_vld_q;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      sp_q <= setpoint_i;
      ms_q <= measured_i;
    end
  end

  pidd_shaper u_shaper (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .update_i   (advance && s0_vld_q),
    .cfg_i      (db_cfg_q),
    .setpoint_i (sp_q),
    .measured_i (ms_q),
    .shaped_o   (shaped)
  );

  pidd_mac u_mac (
    .clk_i     (clk_i),
    .advance_i (advance),
    .gains_i   (gains_q),
    .shaped_i  (shaped),
    .drive_o   (drive_o)
  );

endmodule

// File: hdl/pidd_checker.sv
// Port level checks for the deadband PID controller, bound to the top level.
module pidd_checker import pidd_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic signed [DriveW-1:0]  drive_o
);

  // a waiting result holds its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o))
    else $error("result word changed while stalled");

  // a stalled result holds back the input side
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted while pipeline stalled");

  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result register");

  // with a free output side at each step, an accepted word arrives as a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind positional_pid_with_deadband pidd_checker u_pidd_checker (.*);
